// ----- src/best_fit_free_list_allocator_unit_assert.svh -----
// assertion macros for the best-fit allocator checker
// no dependencies; include once per file that asserts
`ifndef BEST_FIT_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH
`define BEST_FIT_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define BFFL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

// consequent must hold in the same cycle as the antecedent
`define BFFL_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

`endif

// ----- src/bffl_pkg.sv -----
// shared types and constants of the best-fit allocator
// no dependencies
package bffl_pkg;

    localparam int MAX_FREE = 16;
    localparam int MAX_USED = 32;
    localparam logic [31:0] HEADER_BYTES = 32'd24;

    localparam int FREE_AW = $clog2(MAX_FREE);
    localparam int USED_AW = $clog2(MAX_USED);
    localparam int CNT_W   = $clog2(MAX_FREE + 1);

    localparam logic [0:0] OP_ALLOC = 1'b0;
    localparam logic [0:0] OP_FREE  = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [2:0] ST_EXHAUSTED = 3'd2;
    localparam logic [2:0] ST_UNKNOWN   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [0:0]  operation;
        logic [31:0] request_size;
        logic [31:0] block_address;
    } t_in_item;

    typedef struct packed {
        logic [31:0] granted_address;
        logic [31:0] granted_size;
        logic [2:0]  status;
        logic [4:0]  free_regions;
    } t_out_item;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] len;
    } t_region;

endpackage

// ----- src/bffl_ram.sv -----
// generic single-write, single-read synchronous ram, registered read data
// no dependencies
module bffl_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/best_fit_free_list_allocator_unit.sv -----
// best-fit allocator: one item at a time; an allocate scans the free table until an exact fit
// or its end, then moves later entries down when a whole region is taken; a free scans the
// used slots up to the match, passes the free regions below it and shifts entries to insert;
// the single read port of each table ram sets the pace
// synchronous active-low reset: free table empty, no block granted, break pointer zero,
// heap limit 65536; the tables need no clearing pass
module best_fit_free_list_allocator_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bffl_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bffl_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata
);

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK,
        S_ASCAN_RD, S_ASCAN_EV, S_APLACE, S_AUSED,
        S_DROP_RD, S_DROP_WR,
        S_USCAN_RD, S_USCAN_EV, S_FSCAN_RD, S_FSCAN_EV, S_FJOIN,
        S_INS_RD, S_INS_WR,
        S_FIN
    } t_state;

    localparam int FAW = bffl_pkg::FREE_AW;
    localparam int UAW = bffl_pkg::USED_AW;
    localparam int CW  = bffl_pkg::CNT_W;

    t_state                          r_state;
    logic [31:0]                     r_heap_limit;
    logic [31:0]                     r_bp;
    logic [CW-1:0]                   r_count;
    logic [bffl_pkg::MAX_USED-1:0]   r_used_valid;

    // item under work
    logic [0:0]      r_op;
    logic [31:0]     r_size;
    logic [31:0]     r_addr;
    logic [CW-1:0]   r_fidx;     // free table walk index, also insert position
    logic [CW-1:0]   r_shift;
    logic [UAW-1:0]  r_uidx;
    logic [UAW-1:0]  r_slot;
    logic            r_found;
    logic [FAW-1:0]  r_pick_idx;
    logic [31:0]     r_pick_start;
    logic [31:0]     r_pick_len;
    logic [31:0]     r_start;
    logic [31:0]     r_len;
    bffl_pkg::t_region r_prev;
    bffl_pkg::t_region r_next;

    // result holding
    logic [31:0]     r_res_addr;
    logic [31:0]     r_res_size;
    logic [2:0]      r_res_status;
    logic            r_out_valid;
    bffl_pkg::t_out_item r_out_item;

    // table rams
    logic              w_f_we, w_f_re, w_u_we;
    logic [FAW-1:0]    w_f_waddr, w_f_raddr;
    bffl_pkg::t_region w_f_wdata, w_f_rdata, w_u_rdata;

    // combinational decisions
    logic [UAW-1:0]  w_free_slot;
    logic            w_slot_found;
    logic [CW-1:0]   w_fidx_inc;
    logic [CW-1:0]   w_fidx_dec;
    logic [CW-1:0]   w_shift_dec;
    logic [32:0]     w_need;
    logic            w_take_all;
    logic [33:0]     w_brk_sum;
    logic            w_brk_over;
    logic            w_join_prev;
    logic            w_join_next;
    logic            w_tab_full;
    logic            w_addr_hit;

    bffl_ram #(.DEPTH(bffl_pkg::MAX_FREE), .WIDTH($bits(bffl_pkg::t_region))) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (w_f_we),
        .i_waddr (w_f_waddr),
        .i_wdata (w_f_wdata),
        .i_re    (w_f_re),
        .i_raddr (w_f_raddr),
        .o_rdata (w_f_rdata)
    );

    bffl_ram #(.DEPTH(bffl_pkg::MAX_USED), .WIDTH($bits(bffl_pkg::t_region))) u_used_ram (
        .i_clk   (i_clk),
        .i_we    (w_u_we),
        .i_waddr (r_slot),
        .i_wdata ({r_start, r_len}),
        .i_re    (r_state == S_USCAN_RD),
        .i_raddr (r_uidx),
        .o_rdata (w_u_rdata)
    );

    // lowest unused slot of the used table
    always_comb begin
        w_free_slot = '0;
        for (int i = bffl_pkg::MAX_USED - 1; i >= 0; i--) begin
            if (!r_used_valid[i]) begin
                w_free_slot = UAW'(i);
            end
        end
    end
    assign w_slot_found = ~&r_used_valid;

    assign w_fidx_inc  = r_fidx + CW'(1);
    assign w_fidx_dec  = r_fidx - CW'(1);
    assign w_shift_dec = r_shift - CW'(1);

    // split only when more than a header is left over
    assign w_need     = {1'b0, r_size} + {1'b0, bffl_pkg::HEADER_BYTES};
    assign w_take_all = {1'b0, r_pick_len} <= w_need;

    // break growth is checked without wrap
    assign w_brk_sum  = {2'b0, r_bp} + {2'b0, r_size} + {2'b0, bffl_pkg::HEADER_BYTES};
    assign w_brk_over = w_brk_sum > {2'b0, r_heap_limit};

    // payload address match, no wrap
    assign w_addr_hit = ({1'b0, w_u_rdata.start} + {1'b0, bffl_pkg::HEADER_BYTES})
                        == {1'b0, r_addr};

    // neighbor adjacency for coalescing
    assign w_join_prev = (r_fidx != '0) &&
        (({2'b0, r_prev.start} + {2'b0, r_prev.len} + {2'b0, bffl_pkg::HEADER_BYTES})
         == {2'b0, r_start});
    assign w_join_next = (r_fidx < r_count) &&
        (({2'b0, r_start} + {2'b0, r_len} + {2'b0, bffl_pkg::HEADER_BYTES})
         == {2'b0, r_next.start});
    assign w_tab_full  = r_count >= CW'(bffl_pkg::MAX_FREE);

    // free table port control
    always_comb begin
        w_f_re    = 1'b0;
        w_f_raddr = r_fidx[FAW-1:0];
        w_f_we    = 1'b0;
        w_f_waddr = r_fidx[FAW-1:0];
        w_f_wdata = w_f_rdata;
        case (r_state)
            S_ASCAN_RD, S_FSCAN_RD: begin
                w_f_re = 1'b1;
            end
            S_DROP_RD: begin
                w_f_re    = 1'b1;
                w_f_raddr = w_fidx_inc[FAW-1:0];
            end
            S_DROP_WR: begin
                w_f_we = 1'b1;
            end
            S_APLACE: begin
                // shrink the picked region in place on a split
                w_f_we    = r_found && !w_take_all;
                w_f_waddr = r_pick_idx;
                w_f_wdata = {r_pick_start + r_size + bffl_pkg::HEADER_BYTES,
                             r_pick_len - w_need[31:0]};
            end
            S_FJOIN: begin
                if (w_join_prev && w_join_next) begin
                    w_f_we    = 1'b1;
                    w_f_waddr = w_fidx_dec[FAW-1:0];
                    w_f_wdata = {r_prev.start, r_prev.len + bffl_pkg::HEADER_BYTES + r_len
                                 + bffl_pkg::HEADER_BYTES + r_next.len};
                end else if (w_join_prev) begin
                    w_f_we    = 1'b1;
                    w_f_waddr = w_fidx_dec[FAW-1:0];
                    w_f_wdata = {r_prev.start, r_prev.len + bffl_pkg::HEADER_BYTES + r_len};
                end else if (w_join_next) begin
                    w_f_we    = 1'b1;
                    w_f_wdata = {r_start, r_len + bffl_pkg::HEADER_BYTES + r_next.len};
                end
            end
            S_INS_RD: begin
                if (r_shift > r_fidx) begin
                    w_f_re    = 1'b1;
                    w_f_raddr = w_shift_dec[FAW-1:0];
                end else begin
                    // hole is open, drop the block in
                    w_f_we    = 1'b1;
                    w_f_wdata = {r_start, r_len};
                end
            end
            S_INS_WR: begin
                w_f_we    = 1'b1;
                w_f_waddr = r_shift[FAW-1:0];
            end
            default: begin
            end
        endcase
    end

    assign w_u_we = (r_state == S_AUSED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_heap_limit <= 32'd65536;
            r_bp         <= '0;
            r_count      <= '0;
            r_used_valid <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_heap_limit <= i_cfg_wdata;
            end
            // the finish state reloads the result register itself
            if (r_out_valid && i_out_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_in_item.operation;
                        r_size  <= i_in_item.request_size;
                        r_addr  <= i_in_item.block_address;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_res_addr   <= '0;
                    r_res_size   <= '0;
                    r_res_status <= bffl_pkg::ST_OK;
                    r_fidx       <= '0;
                    r_uidx       <= '0;
                    r_found      <= 1'b0;
                    if (r_op == bffl_pkg::OP_ALLOC) begin
                        r_slot <= w_free_slot;
                        if (r_size == '0) begin
                            r_res_status <= bffl_pkg::ST_ZERO_SIZE;
                            r_state      <= S_FIN;
                        end else if (!w_slot_found) begin
                            r_res_status <= bffl_pkg::ST_FULL;
                            r_state      <= S_FIN;
                        end else begin
                            r_state <= S_ASCAN_RD;
                        end
                    end else if (r_addr == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_USCAN_RD;
                    end
                end
                S_ASCAN_RD: begin
                    r_state <= (r_fidx < r_count) ? S_ASCAN_EV : S_APLACE;
                end
                S_ASCAN_EV: begin
                    if (w_f_rdata.len == r_size) begin
                        // exact fit ends the search
                        r_found      <= 1'b1;
                        r_pick_idx   <= r_fidx[FAW-1:0];
                        r_pick_start <= w_f_rdata.start;
                        r_pick_len   <= w_f_rdata.len;
                        r_state      <= S_APLACE;
                    end else begin
                        if (w_f_rdata.len > r_size && (!r_found || w_f_rdata.len < r_pick_len)) begin
                            r_found      <= 1'b1;
                            r_pick_idx   <= r_fidx[FAW-1:0];
                            r_pick_start <= w_f_rdata.start;
                            r_pick_len   <= w_f_rdata.len;
                        end
                        r_fidx  <= w_fidx_inc;
                        r_state <= S_ASCAN_RD;
                    end
                end
                S_APLACE: begin
                    if (r_found) begin
                        r_start <= r_pick_start;
                        if (w_take_all) begin
                            r_len   <= r_pick_len;
                            r_fidx  <= CW'(r_pick_idx);
                            r_state <= S_DROP_RD;
                        end else begin
                            r_len   <= r_size;
                            r_state <= S_AUSED;
                        end
                    end else if (w_brk_over) begin
                        r_res_status <= bffl_pkg::ST_EXHAUSTED;
                        r_state      <= S_FIN;
                    end else begin
                        r_start <= r_bp;
                        r_len   <= r_size;
                        r_bp    <= w_brk_sum[31:0];
                        r_state <= S_AUSED;
                    end
                end
                S_AUSED: begin
                    r_used_valid[r_slot] <= 1'b1;
                    r_res_addr <= r_start + bffl_pkg::HEADER_BYTES;
                    r_res_size <= r_len;
                    r_state    <= S_FIN;
                end
                // close the gap at r_fidx by moving later entries down
                S_DROP_RD: begin
                    if (w_fidx_inc < r_count) begin
                        r_state <= S_DROP_WR;
                    end else begin
                        r_count <= r_count - CW'(1);
                        r_state <= (r_op == bffl_pkg::OP_ALLOC) ? S_AUSED : S_FIN;
                    end
                end
                S_DROP_WR: begin
                    r_fidx  <= w_fidx_inc;
                    r_state <= S_DROP_RD;
                end
                S_USCAN_RD: begin
                    if (r_used_valid[r_uidx]) begin
                        r_state <= S_USCAN_EV;
                    end else if (r_uidx == UAW'(bffl_pkg::MAX_USED - 1)) begin
                        r_res_status <= bffl_pkg::ST_UNKNOWN;
                        r_state      <= S_FIN;
                    end else begin
                        r_uidx <= r_uidx + UAW'(1);
                    end
                end
                S_USCAN_EV: begin
                    if (w_addr_hit) begin
                        r_slot  <= r_uidx;
                        r_start <= w_u_rdata.start;
                        r_len   <= w_u_rdata.len;
                        r_state <= S_FSCAN_RD;
                    end else if (r_uidx == UAW'(bffl_pkg::MAX_USED - 1)) begin
                        r_res_status <= bffl_pkg::ST_UNKNOWN;
                        r_state      <= S_FIN;
                    end else begin
                        r_uidx  <= r_uidx + UAW'(1);
                        r_state <= S_USCAN_RD;
                    end
                end
                S_FSCAN_RD: begin
                    r_state <= (r_fidx < r_count) ? S_FSCAN_EV : S_FJOIN;
                end
                S_FSCAN_EV: begin
                    if (w_f_rdata.start < r_start) begin
                        r_prev  <= w_f_rdata;
                        r_fidx  <= w_fidx_inc;
                        r_state <= S_FSCAN_RD;
                    end else begin
                        r_next  <= w_f_rdata;
                        r_state <= S_FJOIN;
                    end
                end
                S_FJOIN: begin
                    if (!w_join_prev && !w_join_next && w_tab_full) begin
                        r_res_status <= bffl_pkg::ST_FULL;
                        r_state      <= S_FIN;
                    end else begin
                        r_used_valid[r_slot] <= 1'b0;
                        r_res_size <= r_len;
                        if (w_join_prev && w_join_next) begin
                            r_state <= S_DROP_RD;
                        end else if (w_join_prev || w_join_next) begin
                            r_state <= S_FIN;
                        end else begin
                            r_shift <= r_count;
                            r_state <= S_INS_RD;
                        end
                    end
                end
                // open a hole at r_fidx by moving entries up
                S_INS_RD: begin
                    if (r_shift > r_fidx) begin
                        r_state <= S_INS_WR;
                    end else begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_FIN;
                    end
                end
                S_INS_WR: begin
                    r_shift <= w_shift_dec;
                    r_state <= S_INS_RD;
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_item  <= '{granted_address: r_res_addr,
                                         granted_size:    r_res_size,
                                         status:          r_res_status,
                                         free_regions:    5'(r_count)};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- src/bffl_chk.sv -----
// port-level checker for the best-fit allocator, bound to the top level
// depends on bffl_pkg and best_fit_free_list_allocator_unit_assert.svh
`include "best_fit_free_list_allocator_unit_assert.svh"

module bffl_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input bffl_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input bffl_pkg::t_out_item o_out_item,
    input logic                i_cfg_we,
    input logic [31:0]         i_cfg_wdata
);

    // a held result keeps its payload
    `BFFL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item))

    // an accepted item makes the block busy
    `BFFL_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // a new result only comes out of work in progress
    `BFFL_ASSERT_NOW(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid), !$past(o_in_ready))

endmodule

bind best_fit_free_list_allocator_unit bffl_chk u_bffl_chk (.*);
